// ===== rtl/fnvlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvlp_pkg: shared types and constants
// Widths, FNV constants, operation and status codes for the key table.
// ----------------------------------------------------------------------------
package fnvlp_pkg;

  localparam int SLOTS     = 16;
  localparam int KEY_BYTES = 8;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int BYTE_W    = $clog2(KEY_BYTES + 1);

  localparam logic [63:0] HASH_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME  = 64'h00000100000001b3;
  localparam logic [3:0]  LIMIT_RESET = 4'd7;

  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

// ===== rtl/fnvlp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvlp_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fnvlp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fnvlp_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvlp_hash: iterative FNV-1a hash
// Each byte is folded in by a multiply phase and then an add phase; the prime is split into a 2^40 shift and 0x1b3.
// ----------------------------------------------------------------------------
module fnvlp_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  import fnvlp_pkg::*;

  logic [63:0]       h;
  logic [63:0]       x;
  logic [63:0]       kreg;
  logic [BYTE_W-1:0] pos;
  logic              busy;
  logic              phase;
  logic [63:0]       lo_prod;
  logic [7:0]        cur_byte;

  assign cur_byte = kreg[7:0];
  assign hash     = h;

  // x * prime = x * 0x1b3 + (x << 40), with prime = 2^40 + 0x1b3
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        h     <= HASH_OFFSET;
        kreg  <= key;
        pos   <= '0;
      end else if (busy) begin
        if (!phase) begin
          if (cur_byte == 8'd0 || pos == BYTE_W'(KEY_BYTES)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            x       <= h ^ {56'd0, cur_byte};
            lo_prod <= (h ^ {56'd0, cur_byte}) * 64'h1b3;
            phase   <= 1'b1;
          end
        end else begin
          // add the 2^40 term
          h     <= lo_prod + {x[23:0], 40'd0};
          kreg  <= {8'd0, kreg[63:8]};
          pos   <= pos + 1'b1;
          phase <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/fnv_linear_probe_key_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv_linear_probe_key_table: hashed key-value table, linear probing
// Channel  | handshake          | payload
// in       | in_valid/in_ready  | func, key, value
// out      | out_valid/out_ready| status, read_value, live_count
// cfg      | cfg_we             | cfg_data (load_limit_tenths)
// One item at a time: the hash folds in one key byte after another (up to 8),
// then the probe reads and checks one slot after another (up to SLOTS), then
// the action and output states follow before the next transfer.
// Reset clears all tags and the count at once; no clearing pass.
// in_ready drops while an item is at work or its result waits on out_ready.
// ----------------------------------------------------------------------------
module fnv_linear_probe_key_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] read_value,
  output logic [4:0]  live_count
);
  import fnvlp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_ACT   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t            state;
  logic [3:0]        limit;
  logic [1:0]        tag [SLOTS];
  logic [CNT_W-1:0]  count;
  logic [1:0]        op;
  logic [63:0]       k;
  logic [63:0]       v;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  n;
  logic              hit, have_empty, have_tomb;
  logic [IDX_W-1:0]  hit_at, empty_at, tomb_at;
  logic              hstart, hdone;
  logic [63:0]       hval;
  logic              kwe, vwe;
  logic [IDX_W-1:0]  waddr;
  logic [63:0]       krd, vrd;
  logic [63:0]       trimmed;
  logic              zseen;
  logic              over;

  // trim key after the first zero byte
  always_comb begin
    trimmed = '0;
    zseen   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (key[8*i +: 8] == 8'd0 || i >= KEY_BYTES) zseen = 1'b1;
      if (!zseen) trimmed[8*i +: 8] = key[8*i +: 8];
    end
  end

  fnvlp_hash u_hash (
    .clk(clk), .rst(rst), .start(hstart), .key(k), .done(hdone), .hash(hval)
  );

  fnvlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(kwe), .waddr(waddr), .wdata(k), .raddr(idx), .rdata(krd)
  );
  fnvlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_vals (
    .clk(clk), .we(vwe), .waddr(waddr), .wdata(v), .raddr(idx), .rdata(vrd)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign live_count = 5'(count);
  assign over = (((CNT_W + 4)'(count) * (CNT_W + 4)'(10)) >> IDX_W) >=
                (CNT_W + 4)'(limit);

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      limit  <= LIMIT_RESET;
      count  <= '0;
      hstart <= 1'b0;
      kwe    <= 1'b0;
      vwe    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) tag[i] <= TAG_EMPTY;
    end else begin
      hstart <= 1'b0;
      kwe    <= 1'b0;
      vwe    <= 1'b0;
      if (cfg_we) limit <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= func; k <= trimmed; v <= value;
            hit <= 1'b0; have_empty <= 1'b0; have_tomb <= 1'b0;
            n <= '0;
            status <= ST_MISSING;
            read_value <= '1;
            if (func inside {FUNC_SET, FUNC_GET, FUNC_DEL}) begin
              hstart <= 1'b1;
              state  <= S_HASH;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_HASH: begin
          if (hdone) begin
            idx   <= hval[IDX_W-1:0];
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (tag[idx] == TAG_EMPTY) begin
            have_empty <= 1'b1; empty_at <= idx; state <= S_ACT;
          end else if (tag[idx] == TAG_LIVE && krd == k) begin
            hit <= 1'b1; hit_at <= idx; state <= S_ACT;
          end else begin
            if (tag[idx] == TAG_TOMB && !have_tomb) begin
              have_tomb <= 1'b1; tomb_at <= idx;
            end
            idx <= idx + 1'b1;
            n   <= n + 1'b1;
            state <= (n == CNT_W'(SLOTS - 1)) ? S_ACT : S_READ;
          end
        end
        S_ACT: begin
          state <= S_OUT;
          case (op)
            FUNC_SET: begin
              if (hit) begin
                waddr <= hit_at; vwe <= 1'b1; status <= ST_UPDATED;
              end else if (over || !(have_tomb || have_empty)) begin
                status <= ST_FULL;
              end else begin
                waddr <= have_tomb ? tomb_at : empty_at;
                kwe <= 1'b1; vwe <= 1'b1;
                tag[have_tomb ? tomb_at : empty_at] <= TAG_LIVE;
                count <= count + 1'b1;
                status <= ST_INSERTED;
              end
            end
            FUNC_GET: begin
              if (hit) begin
                read_value <= vrd; status <= ST_FOUND;
              end
            end
            default: begin
              if (hit) begin
                tag[hit_at] <= TAG_TOMB;
                if (count != '0) count <= count - 1'b1;
                status <= ST_FOUND;
              end
            end
          endcase
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fnvlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnvlp_checker: port-level checks for the key table
// Watches the handshake and result fields over time.
// ----------------------------------------------------------------------------
module fnvlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [63:0] read_value,
  input logic [4:0]  live_count
);
  import fnvlp_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("stall");
  // no new transfer while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("overlap");
  // all ones unless found
  a_rd: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> read_value == '1) else $error("read value");
  // status in range
  a_st: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL) else $error("status");
  // live count never above the slot count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> live_count <= 5'(SLOTS)) else $error("live count");

endmodule

bind fnv_linear_probe_key_table fnvlp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .read_value(read_value), .live_count(live_count)
);

// ===== tb/fnv_linear_probe_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv_linear_probe_key_table_tb: self-checking bench for the hashed key table
// Drives set/get/delete requests over valid/ready with random gaps and output
// stalls, predicts each result with a behavioral table, and compares fields.
// ----------------------------------------------------------------------------
module fnv_linear_probe_key_table_tb;
  import fnvlp_pkg::*;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [4:0]  live_count;
  } table_result_t;

  int unsigned error_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Behavioral key table and queue of predicted results
  class key_table_scoreboard;
    logic [1:0]    tag [SLOTS];
    logic [63:0]   skey [SLOTS];
    logic [63:0]   sval [SLOTS];
    int unsigned   entries;
    logic [3:0]    limit;
    table_result_t pending [$];

    function new();
      foreach (tag[i]) begin
        tag[i] = TAG_EMPTY;
        skey[i] = '0;
        sval[i] = '0;
      end
      entries = 0;
      limit = LIMIT_RESET;
    endfunction

    // Keep bytes up to the first zero byte
    function logic [63:0] trimmed(input logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (k[8*i +: 8] == 8'h00) break;
        r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
    endfunction

    function logic [63:0] fnv1a(input logic [63:0] k);
      logic [63:0] h;
      h = HASH_OFFSET;
      for (int i = 0; i < 8; i++) begin
        if (k[8*i +: 8] == 8'h00) break;
        h = (h ^ {56'd0, k[8*i +: 8]}) * HASH_PRIME;
      end
      return h;
    endfunction

    function void note_request(input logic [1:0] f, input logic [63:0] k_in,
                               input logic [63:0] v);
      table_result_t r;
      logic [63:0] k;
      int idx, hit_at, empty_at, tomb_at;
      bit hit, have_empty, have_tomb;
      k = trimmed(k_in);
      r.status = ST_MISSING;
      r.read_value = '1;
      hit = 0; have_empty = 0; have_tomb = 0;
      hit_at = 0; empty_at = 0; tomb_at = 0;
      if (f <= FUNC_DEL) begin
        idx = int'(fnv1a(k) % SLOTS);
        // Walk the probe path, stopping on an empty slot or a match
        for (int n = 0; n < SLOTS; n++) begin
          if (tag[idx] == TAG_EMPTY) begin
            have_empty = 1; empty_at = idx;
            break;
          end
          if (tag[idx] == TAG_TOMB) begin
            if (!have_tomb) begin
              have_tomb = 1; tomb_at = idx;
            end
          end else if (tag[idx] == TAG_LIVE && skey[idx] == k) begin
            hit = 1; hit_at = idx;
            break;
          end
          idx = (idx + 1) % SLOTS;
        end
        if (f == FUNC_SET) begin
          if (hit) begin
            sval[hit_at] = v;
            r.status = ST_UPDATED;
          end else if (entries * 10 / SLOTS >= limit) begin
            r.status = ST_FULL;
          end else if (have_tomb || have_empty) begin
            idx = have_tomb ? tomb_at : empty_at;
            tag[idx] = TAG_LIVE;
            skey[idx] = k;
            sval[idx] = v;
            entries++;
            r.status = ST_INSERTED;
          end else begin
            r.status = ST_FULL;
          end
        end else if (f == FUNC_GET) begin
          if (hit) begin
            r.read_value = sval[hit_at];
            r.status = ST_FOUND;
          end
        end else if (hit) begin
          tag[hit_at] = TAG_TOMB;
          sval[hit_at] = '0;
          if (entries > 0) entries--;
          r.status = ST_FOUND;
        end
      end
      r.live_count = entries[4:0];
      pending.push_back(r);
    endfunction

    task check_result(input table_result_t got);
      table_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.status, '0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.live_count !== want.live_count)
        report_mismatch("live_count", got.live_count, want.live_count);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  func = FUNC_GET;
  logic [63:0] key = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [63:0] read_value;
  logic [4:0]  live_count;

  key_table_scoreboard sb = new();
  bit stall_enable = 1;
  logic [63:0] key_pool [16];

  fnv_linear_probe_key_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .key(key),
    .value(value), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .read_value(read_value), .live_count(live_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 4);
  endfunction

  // Sample results at the rising edge; update ready at the falling edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status: status, read_value: read_value,
                        live_count: live_count});
  end

  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = stall_enable ? gap_cycles() : 0;
      out_ready <= (hold == 0);
      repeat (hold > 0 ? hold : 1) @(negedge clk);
      out_ready <= 1;
      @(negedge clk);
    end
  end

  // Present one request and hold it until the transfer; valid stays high
  // into the next request when it follows with no gap
  task automatic send_request(input logic [1:0] f, input logic [63:0] k,
                              input logic [63:0] v, input bit gaps);
    int idle;
    idle = gaps ? gap_cycles() : 0;
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 0;
      repeat (idle) @(negedge clk);
    end
    func <= f;
    key <= k;
    value <= v;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(f, k, v);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_limit(input logic [3:0] lim);
    drain_results();
    cfg_data <= lim;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.limit = lim;
  endtask

  // Random key of 0..8 bytes, sometimes with bytes past a zero byte
  function automatic logic [63:0] make_key();
    logic [63:0] k;
    int len;
    len = $urandom_range(0, 8);
    k = {$urandom(), $urandom()};
    for (int i = 0; i < 8; i++)
      if (i >= len && $urandom_range(0, 3) != 0) k[8*i +: 8] = 8'h00;
    return k;
  endfunction

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return FUNC_SET;
    if (r < 75) return FUNC_GET;
    if (r < 97) return FUNC_DEL;
    return FUNC_UNKNOWN;
  endfunction

  initial begin
    logic [63:0] k;
    foreach (key_pool[i]) key_pool[i] = make_key();
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: edges of the key, every op, unknown op, full table
    send_request(FUNC_GET, 64'd0, 64'd0, 0);
    send_request(FUNC_SET, 64'd0, 64'h0, 0);
    send_request(FUNC_SET, 64'h00ff_0000, 64'h1234, 0);
    send_request(FUNC_GET, 64'd0, 64'd0, 0);
    send_request(FUNC_SET, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0);
    send_request(FUNC_SET, 64'h4141_0041, 64'h5, 0);
    send_request(FUNC_GET, 64'h41, 64'd0, 0);
    send_request(FUNC_GET, 64'hffff_ffff_ffff_ffff, 64'd0, 0);
    send_request(FUNC_DEL, 64'h41, 64'd0, 0);
    send_request(FUNC_DEL, 64'h41, 64'd0, 0);
    send_request(FUNC_UNKNOWN, 64'h42, 64'd9, 0);
    send_request(FUNC_SET, 64'h41, 64'h77, 0);
    send_request(FUNC_SET, 64'h41, 64'h78, 0);
    write_limit(4'd0);
    send_request(FUNC_SET, 64'h43, 64'h1, 0);
    send_request(FUNC_SET, 64'h41, 64'h2, 0);
    write_limit(4'd15);
    for (int i = 0; i < 18; i++)
      send_request(FUNC_SET, 64'h61 + i, {$urandom(), $urandom()}, 0);
    for (int i = 0; i < 4; i++)
      send_request(FUNC_DEL, 64'h61 + 2 * i, 64'd0, 0);

    // Random phases over several limits; pool keys to reach hits
    foreach (key_pool[i]) key_pool[i] = make_key();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_limit(4'd10);
        1: write_limit(4'd1);
        2: write_limit(4'd7);
        3: write_limit(4'd15);
        4: write_limit(4'd5);
        5: write_limit(4'd11);
        default: write_limit(4'($urandom_range(0, 15)));
      endcase
      stall_enable = (phase != 3);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) drain_results();
        k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 15)] : make_key();
        send_request(pick_func(), k, {$urandom(), $urandom()}, stall_enable);
      end
      if ($urandom_range(0, 1)) key_pool[$urandom_range(0, 15)] = make_key();
    end

    drain_results();
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fnvlp_pkg.sv
rtl/fnvlp_ram.sv
rtl/fnvlp_hash.sv
rtl/fnv_linear_probe_key_table.sv
rtl/fnvlp_checker.sv
tb/fnv_linear_probe_key_table_tb.sv
